FILE: rtl/core/cdq_pkg.sv
// Shared types and constants for the circular deque.
`default_nettype none

package cdq_pkg;

  localparam int unsigned DATA_W = 32;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  removed_value;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  rear_value;
    logic                      is_empty;
    logic                      is_full;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the accepted item
    logic exec;     // perform the operation on indices and memory
    logic capture;  // take the registered memory read into the end word
    logic emit;     // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_read;  // operation refills an end word from memory
    logic out_busy;   // result register holds a stalled transfer
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/cdq_ctrl.sv
// Sequencing controller for the circular deque.
`default_nettype none

module cdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire cdq_pkg::stat_t stat,
  output cdq_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state;

  // Items are taken only while idle
  assign item_stall = (state != ST_IDLE);

  // Commands decoded from the current state
  always_comb begin
    cmd         = '0;
    cmd.load    = (state == ST_IDLE) && item_valid;
    cmd.exec    = (state == ST_EXEC);
    cmd.capture = (state == ST_READ);
    cmd.emit    = (state == ST_EMIT) && !stat.out_busy;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= stat.need_read ? ST_READ : ST_EMIT;
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!stat.out_busy) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdq_dpath.sv
// Datapath of the circular deque: slot memory, end indices and result register.
`default_nettype none

module cdq_dpath #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cdq_pkg::item_t  item,
  input  wire cdq_pkg::cmd_t   cmd,
  output cdq_pkg::stat_t       stat,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output cdq_pkg::result_t     result
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam int unsigned DW = cdq_pkg::DATA_W;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    ring_prev = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // Slot memory, written before it is ever read
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data;

  // Control state
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic             empty_mark;

  // Payload registers
  cdq_pkg::item_t   cur;
  logic [DW-1:0]    front_word;
  logic [DW-1:0]    rear_word;
  logic [DW-1:0]    removed;
  cdq_pkg::status_t status;

  logic             is_push;
  logic             full;
  logic             do_write;
  logic             rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  // Operation decode
  always_comb begin
    is_push  = cur.kind inside {cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_REAR};
    full     = !empty_mark && (ring_next(tail) == head);
    if (empty_mark) begin
      wr_addr = '0;
    end else if (cur.kind == cdq_pkg::KIND_PUSH_FRONT) begin
      wr_addr = ring_prev(head);
    end else begin
      wr_addr = ring_next(tail);
    end
    // Pop that leaves entries behind refetches the new end word
    stat.need_read = !is_push && !empty_mark && (head != tail);
    rd_addr        = (cur.kind == cdq_pkg::KIND_POP_FRONT) ? ring_next(head) : ring_prev(tail);
    stat.out_busy  = result_valid && result_stall;
  end

  // Memory enables, kept apart from the status decode
  assign do_write = cmd.exec && is_push && (empty_mark || !full);
  assign rd_en    = cmd.exec && stat.need_read;

  // Memory ports
  always_ff @(posedge clk) begin
    if (do_write) mem[wr_addr] <= cur.value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= item;
  end

  // Indices and empty mark
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      empty_mark <= 1'b1;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (empty_mark) begin
          head       <= '0;
          tail       <= '0;
          empty_mark <= 1'b0;
        end else if (!full) begin
          if (cur.kind == cdq_pkg::KIND_PUSH_FRONT) head <= ring_prev(head);
          else tail <= ring_next(tail);
        end
      end else if (!empty_mark) begin
        if (head == tail) begin
          head       <= '0;
          tail       <= '0;
          empty_mark <= 1'b1;
        end else if (cur.kind == cdq_pkg::KIND_POP_FRONT) begin
          head <= ring_next(head);
        end else begin
          tail <= ring_prev(tail);
        end
      end
    end
  end

  // Cached end words, status and removed word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status  <= cdq_pkg::STATUS_OK;
      removed <= '0;
      if (is_push) begin
        if (empty_mark) begin
          front_word <= cur.value;
          rear_word  <= cur.value;
        end else if (full) begin
          status <= cdq_pkg::STATUS_OVERFLOW;
        end else if (cur.kind == cdq_pkg::KIND_PUSH_FRONT) begin
          front_word <= cur.value;
        end else begin
          rear_word <= cur.value;
        end
      end else if (empty_mark) begin
        status <= cdq_pkg::STATUS_UNDERFLOW;
      end else if (cur.kind == cdq_pkg::KIND_POP_FRONT || head == tail) begin
        removed <= front_word;
      end else begin
        removed <= rear_word;
      end
    end else if (cmd.capture) begin
      if (cur.kind == cdq_pkg::KIND_POP_FRONT) front_word <= rd_data;
      else rear_word <= rd_data;
    end
  end

  // Result register and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status        <= status;
      result.removed_value <= removed;
      result.front_value   <= empty_mark ? '0 : front_word;
      result.rear_value    <= empty_mark ? '0 : rear_word;
      result.is_empty      <= empty_mark;
      result.is_full       <= full;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/circular_deque.sv
// Circular deque: double-ended queue over a ring of DEPTH 32-bit slots.
// Usage:
//   The item channel (item_valid, item_stall, item) carries one operation per
//   transfer: push front, push rear, pop front or pop rear, with a data word.
//   The result channel (result_valid, result_stall, result) returns exactly one
//   result per item: status, removed word, front and rear words after the
//   operation (zero when empty) and the empty and full flags.
//   One item is in flight at a time. A push, a refused operation or a pop of
//   the last entry goes from the execute state straight to the emit state;
//   any other pop passes through an extra read state, for the registered read
//   port of the slot memory that refetches the new end word. The result is
//   loaded in the emit state, once the output register is free.
//   The result sits in an output register; while the receiver stalls it holds
//   and the block finishes the following item but waits to load its result.
//   Synchronous reset empties the deque and drops any pending result; the slot
//   memory is not cleared, since only written slots are ever read.
`default_nettype none

module circular_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire cdq_pkg::item_t    item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output cdq_pkg::result_t       result
);

  cdq_pkg::cmd_t  cmd;
  cdq_pkg::stat_t stat;

  // Sequencer
  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Storage and result path
  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
